[rtl/core/bocc_pkg.sv]
`timescale 1ns / 1ps

package bocc_pkg;

  localparam int RowW     = 64;
  localparam int CfgW     = 7;
  localparam int MaxWidth = 64;
  localparam logic [CfgW-1:0] WidthRst = 7'd64;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [RowW-1:0] mask;
    logic            last;
    logic            had_prev;
    logic            cmp_en;
  } entry_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic            eoi;
    logic            possible;
  } result_t;

  function automatic logic [RowW-1:0] width_mask(logic [CfgW-1:0] w);
    logic [CfgW-1:0] wc;
    wc = (w > CfgW'(MaxWidth)) ? CfgW'(MaxWidth) : w;
    if (wc >= CfgW'(RowW)) begin
      return '1;
    end
    return (RowW'(1) << wc) - RowW'(1);
  endfunction

  // outside pixels count as set
  function automatic logic [RowW-1:0] and3(logic [RowW-1:0] a, logic [RowW-1:0] m);
    logic [RowW-1:0] x;
    x = a | ~m;
    return x & {x[RowW-2:0], 1'b1} & {1'b1, x[RowW-1:1]};
  endfunction

  // clipped to the row
  function automatic logic [RowW-1:0] or3(logic [RowW-1:0] a, logic [RowW-1:0] m);
    logic [RowW-1:0] y;
    y = a & m;
    return (y | {y[RowW-2:0], 1'b0} | {1'b0, y[RowW-1:1]}) & m;
  endfunction

  function automatic logic [RowW-1:0] erode(logic [RowW-1:0] a, logic [RowW-1:0] b,
                                            logic [RowW-1:0] c, logic [RowW-1:0] m);
    return and3(a, m) & and3(b, m) & and3(c, m) & m;
  endfunction

  function automatic logic differs(logic [RowW-1:0] d, logic [RowW-1:0] orig,
                                   logic [RowW-1:0] m);
    return |((d ^ orig) & m);
  endfunction

endpackage

[rtl/core/bocc_queue.sv]
`timescale 1ns / 1ps

module bocc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             pop_valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/bocc_front.sv]
`timescale 1ns / 1ps

module bocc_front
  import bocc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic [RowW-1:0] in_row_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            push_o,
  output entry_t          entry_o,
  input  logic            push_ready_i
);

  logic [CfgW-1:0] width_q;
  logic [1:0]      rows_seen_q, rows_seen_d;
  logic            accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = in_valid_i;

  always_comb begin
    entry_o.row      = in_row_i;
    entry_o.mask     = width_mask(width_q);
    entry_o.last     = in_last_i;
    entry_o.had_prev = (rows_seen_q != 2'd0);
    entry_o.cmp_en   = rows_seen_q[1];
  end

  always_comb begin
    rows_seen_d = rows_seen_q;
    if (accept) begin
      if (in_last_i) begin
        rows_seen_d = 2'd0;
      end else if (rows_seen_q != 2'd3) begin
        rows_seen_d = rows_seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthRst;
      rows_seen_q <= 2'd0;
    end else begin
      rows_seen_q <= rows_seen_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/core/bocc_back.sv]
`timescale 1ns / 1ps

module bocc_back
  import bocc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  output logic    out_valid_o,
  output result_t out_o,
  input  logic    out_ready_i
);

  logic [RowW-1:0] op1_q, op2_q, ep1_q, ep2_q;
  logic            mis_q;
  logic            out_valid_q, out_valid_d;
  logic            pend_valid_q, pend_valid_d;
  result_t         out_q, pend_q;

  logic [RowW-1:0] m, e, ef, ep1_n, ep2_n;
  logic            mm1, mm2, mm3, mis_all, out_free, had, two;
  result_t         e_word, ef_word;

  assign m        = entry_i.mask;
  assign had      = entry_i.had_prev;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = q_valid_i && !pend_valid_q && out_free;
  assign two      = had && entry_i.last;

  always_comb begin
    e     = erode(op2_q, op1_q, entry_i.row, m);
    mm1   = entry_i.cmp_en && differs(or3(ep2_q, m) | or3(ep1_q, m) | or3(e, m), op2_q, m);
    ep1_n = had ? e : ep1_q;
    ep2_n = had ? ep1_q : ep2_q;
    ef    = erode(op1_q, entry_i.row, '1, m);
    mm2   = had && differs(or3(ep2_n, m) | or3(ep1_n, m) | or3(ef, m), op1_q, m);
    mm3   = differs(or3(ep1_n, m) | or3(ef, m), entry_i.row, m);
    mis_all = mis_q || mm1 || mm2 || mm3;

    e_word.row       = e;
    e_word.eoi       = 1'b0;
    e_word.possible  = 1'b0;
    ef_word.row      = ef;
    ef_word.eoi      = 1'b1;
    ef_word.possible = !mis_all;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end else begin
        out_valid_d  = pop_o && (had || entry_i.last);
        pend_valid_d = pop_o && two;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      op1_q        <= '1;
      op2_q        <= '1;
      ep1_q        <= '0;
      ep2_q        <= '0;
      mis_q        <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (pop_o) begin
        if (entry_i.last) begin
          op1_q <= '1;
          op2_q <= '1;
          ep1_q <= '0;
          ep2_q <= '0;
          mis_q <= 1'b0;
        end else begin
          op1_q <= entry_i.row;
          op2_q <= op1_q;
          ep1_q <= ep1_n;
          ep2_q <= ep2_n;
          mis_q <= mis_q || mm1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && pend_valid_q) begin
      out_q <= pend_q;
    end else if (out_free && pop_o) begin
      out_q <= had ? e_word : ef_word;
    end
    if (pop_o && two) begin
      pend_q <= ef_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending word without occupied output");

  a_pend_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> pend_q.eoi)
    else $error("pending word is not the end of image");

  a_possible_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.eoi) |-> !out_q.possible)
    else $error("possible set on a non-final word");

  a_no_pop_while_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && two && !(out_valid_q && !out_ready_i)) |=> (out_valid_q && pend_valid_q))
    else $error("two-word row lost a word");

endmodule

[rtl/core/binary_opening_check_3x3_unit.sv]
`timescale 1ns / 1ps
// An accepted row is queued; the word it releases is then set on the output register.
// One row per cycle while the queue has room; a last row that follows other rows yields
// two words, the second held pending and blocking the queue pop until it moves out.
// Reset (async, active low) clears the image state and the queue; width resets to 64.

module binary_opening_check_3x3_unit
  import bocc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // row_bits
  input  logic         s_axis_tlast,   // is_last_row
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // eroded_row
  output logic         m_axis_tlast,   // end_of_image
  output logic         m_axis_tuser    // possible
);

  logic    push, push_ready, pop, q_valid;
  entry_t  entry_in, entry_out;
  result_t res;

  bocc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_row_i    (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .entry_o     (entry_in),
    .push_ready_i(push_ready)
  );

  bocc_queue #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     (entry_in),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .rdata_o     (entry_out),
    .pop_valid_o (q_valid)
  );

  bocc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .entry_i    (entry_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_o      (res),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = res.row;
  assign m_axis_tlast = res.eoi;
  assign m_axis_tuser = res.possible;

endmodule
